/* rtl/kuf_pkg.sv */
// ----------------------------------------------------------------------------
// kuf_pkg
// shared types and codes of the union-find edge acceptor
// ----------------------------------------------------------------------------
`default_nettype none

package kuf_pkg;

  // rank field of the disjoint-set table
  localparam int unsigned RANK_W   = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  // running total, unsigned Q40.16
  localparam int unsigned TOTAL_W  = 56;

  // input item action codes
  localparam logic ACTION_EDGE  = 1'b0;
  localparam logic ACTION_CLEAR = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_EDGE    = 2'd0;
  localparam logic [1:0] STATUS_RANGE   = 2'd1;
  localparam logic [1:0] STATUS_CLEARED = 2'd2;

  // write strobes of the table
  typedef struct packed {
    logic parent_we;
    logic rank_we;
  } kuf_wr_t;

endpackage

`default_nettype wire

/* rtl/kruskal_union_find_edge_acceptor_core.sv */
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_acceptor_core
// final kruskal stage: disjoint-set table with union by rank and path
// compression, saturating total of accepted edge weights
// ----------------------------------------------------------------------------
// Edges arrive sorted by weight. For each edge item the block walks from
// vertex_a up to its root, walks the path again pointing every node at the
// root, then does the same for vertex_b, and links the two roots when they
// differ (lower rank under higher, vertex_a's root under vertex_b's on a tie).
// One result item leaves per input item. The table has a single read port,
// which chases one parent pointer per cycle during a walk. An edge with
// an id at or above the vertex count (or MAX_VERTICES) skips the walks
// and goes straight to its result. After reset and after every clear item
// the table is swept once, one entry a cycle, and no item is taken until
// the sweep ends; configuration writes are taken at any time. An input
// item may be taken while the previous result still waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module kruskal_union_find_edge_acceptor_core
  import kuf_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned WEIGHT_BITS  = 48
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: vertex_count
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata,
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,   // vertex_a[9:0], vertex_b[19:10], weight[67:20], zero
  input  wire logic [0:0]  s_tuser,   // action[0]
  // result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [63:0] m_tdata,   // accepted[0], total[56:1], zero
  output logic      [1:0]  m_tuser    // status[1:0]
);

  // vertex id width inside the table
  localparam int unsigned VW   = $clog2(MAX_VERTICES);
  localparam int unsigned IW   = (VW > 10) ? VW : 10;
  // width that holds both the vertex count register and MAX_VERTICES
  localparam int unsigned CNTW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned LW   = (CNTW > 11) ? CNTW : 11;
  // only the low WEIGHT_BITS of the weight take part
  localparam logic [TOTAL_W:0] WMASK_WIDE = ((TOTAL_W+1)'(1) << WEIGHT_BITS)
                                            - (TOTAL_W+1)'(1);
  localparam logic [TOTAL_W-1:0] WMASK = WMASK_WIDE[TOTAL_W-1:0];

  typedef enum logic [2:0] {
    ST_SWEEP,   // clearing pass over the table
    ST_IDLE,    // waiting for an item
    ST_UP,      // walk toward the root, one parent a cycle
    ST_COMP,    // second walk, point each node at the root
    ST_LINK,    // join the two roots, add weight
    ST_EMIT     // hand the result to the output register
  } state_t;

  // input fields
  logic              in_action;
  logic [9:0]        in_vertex_a;
  logic [9:0]        in_vertex_b;
  logic [47:0]       in_weight;
  logic [IW-1:0]     va_full;
  logic [IW-1:0]     vb_full;
  logic              in_range;

  // registers
  state_t            state, state_next;
  logic [10:0]       vertex_count;
  logic [VW-1:0]     node, node_next;         // entry whose data the table returns
  logic [VW-1:0]     start, start_next;       // first vertex of the current walk
  logic [VW-1:0]     start_b, start_b_next;
  logic              phase_b, phase_b_next;   // walking vertex_b
  logic [VW-1:0]     root, root_next;
  logic [RANK_W-1:0] root_rank, root_rank_next;
  logic [VW-1:0]     root_a, root_a_next;
  logic [RANK_W-1:0] rank_a, rank_a_next;
  logic [TOTAL_W-1:0] weight_reg, weight_reg_next;
  logic [TOTAL_W-1:0] total, total_next;
  logic [VW-1:0]     sweep_cnt, sweep_cnt_next;
  logic              clearing, clearing_next;
  logic              res_accepted, res_accepted_next;
  logic [1:0]        res_status, res_status_next;
  logic              out_accepted, out_accepted_next;
  logic [TOTAL_W-1:0] out_total, out_total_next;
  logic [1:0]        out_status, out_status_next;
  logic              m_tvalid_next;

  // walk end and arithmetic
  logic              walk_end;
  logic [VW-1:0]     end_root;
  logic [RANK_W-1:0] end_rank;
  logic [TOTAL_W:0]  sum;

  // table ports
  kuf_wr_t           wr;
  logic [VW-1:0]     pw_addr, pw_data, rw_addr;
  logic [RANK_W-1:0] rw_data;
  logic [VW-1:0]     rd_parent;
  logic [RANK_W-1:0] rd_rank;

  assign in_action   = s_tuser[0];
  assign in_vertex_a = s_tdata[9:0];
  assign in_vertex_b = s_tdata[19:10];
  assign in_weight   = s_tdata[67:20];
  assign va_full     = IW'(in_vertex_a);
  assign vb_full     = IW'(in_vertex_b);

  // ids must sit below min(vertex_count, MAX_VERTICES)
  assign in_range = (LW'(in_vertex_a) < LW'(vertex_count)) &&
                    (LW'(in_vertex_a) < LW'(MAX_VERTICES)) &&
                    (LW'(in_vertex_b) < LW'(vertex_count)) &&
                    (LW'(in_vertex_b) < LW'(MAX_VERTICES));

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {7'd0, out_total, out_accepted};
  assign m_tuser  = out_status;

  // saturating add, carry out means overflow
  assign sum = {1'b0, total} + {1'b0, weight_reg};

  // the table read is registered and returns mem[node] from the edge at which
  // node is loaded, so the read address is the value node takes at that edge
  kuf_table #(
    .DEPTH (MAX_VERTICES)
  ) u_table (
    .clk          (clk),
    .wr           (wr),
    .parent_waddr (pw_addr),
    .parent_wdata (pw_data),
    .rank_waddr   (rw_addr),
    .rank_wdata   (rw_data),
    .raddr        (node_next),
    .parent_rdata (rd_parent),
    .rank_rdata   (rd_rank)
  );

  always_comb begin
    state_next        = state;
    node_next         = node;
    start_next        = start;
    start_b_next      = start_b;
    phase_b_next      = phase_b;
    root_next         = root;
    root_rank_next    = root_rank;
    root_a_next       = root_a;
    rank_a_next       = rank_a;
    weight_reg_next   = weight_reg;
    total_next        = total;
    sweep_cnt_next    = sweep_cnt;
    clearing_next     = clearing;
    res_accepted_next = res_accepted;
    res_status_next   = res_status;
    out_accepted_next = out_accepted;
    out_total_next    = out_total;
    out_status_next   = out_status;
    m_tvalid_next     = m_tvalid && !m_tready;
    wr                = '0;
    pw_addr           = node;
    pw_data           = root;
    rw_addr           = sweep_cnt;
    rw_data           = '0;
    walk_end          = 1'b0;
    end_root          = root;
    end_rank          = root_rank;

    case (state)
      ST_SWEEP: begin
        // every entry back to its own set with rank zero
        wr.parent_we = 1'b1;
        wr.rank_we   = 1'b1;
        pw_addr      = sweep_cnt;
        pw_data      = sweep_cnt;
        if (sweep_cnt == VW'(MAX_VERTICES - 1)) begin
          state_next    = ST_IDLE;
          clearing_next = 1'b0;
        end else begin
          sweep_cnt_next = sweep_cnt + VW'(1);
        end
      end

      ST_IDLE: begin
        node_next = va_full[VW-1:0];
        if (s_tvalid) begin
          if (in_action == ACTION_CLEAR) begin
            total_next        = '0;
            res_accepted_next = 1'b0;
            res_status_next   = STATUS_CLEARED;
            clearing_next     = 1'b1;
            state_next        = ST_EMIT;
          end else if (!in_range) begin
            res_accepted_next = 1'b0;
            res_status_next   = STATUS_RANGE;
            state_next        = ST_EMIT;
          end else begin
            start_next      = va_full[VW-1:0];
            start_b_next    = vb_full[VW-1:0];
            phase_b_next    = 1'b0;
            weight_reg_next = TOTAL_W'(in_weight) & WMASK;
            state_next      = ST_UP;
          end
        end
      end

      ST_UP: begin
        if (rd_parent == node) begin
          if (start == node) begin
            // start vertex is its own root, nothing to compress
            walk_end = 1'b1;
            end_root = node;
            end_rank = rd_rank;
          end else begin
            root_next      = node;
            root_rank_next = rd_rank;
            node_next      = start;
            state_next     = ST_COMP;
          end
        end else begin
          node_next = rd_parent;
        end
      end

      ST_COMP: begin
        // node is never the root here; repoint it
        wr.parent_we = 1'b1;
        if (rd_parent == root) begin
          walk_end = 1'b1;
        end else begin
          node_next = rd_parent;
        end
      end

      ST_LINK: begin
        res_status_next   = STATUS_EDGE;
        res_accepted_next = (root_a != root);
        if (root_a != root) begin
          total_next   = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
          wr.parent_we = 1'b1;
          if (rank_a > root_rank) begin
            pw_addr = root;
            pw_data = root_a;
          end else begin
            pw_addr = root_a;
            pw_data = root;
            // tie: vertex_b's root grows, rank stops at its maximum
            if (rank_a == root_rank && root_rank != RANK_MAX) begin
              wr.rank_we = 1'b1;
              rw_addr    = root;
              rw_data    = root_rank + RANK_W'(1);
            end
          end
        end
        state_next = ST_EMIT;
      end

      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next     = 1'b1;
          out_accepted_next = res_accepted;
          out_total_next    = total;
          out_status_next   = res_status;
          sweep_cnt_next    = '0;
          state_next        = clearing ? ST_SWEEP : ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // end of one root walk: keep vertex_a's root, go on with vertex_b, or link.
    // the last compress write may hit vertex_b's entry in the same cycle that
    // entry is read; the old pointer still leads to the same root, and the
    // compress walk reads it again later
    if (walk_end) begin
      if (!phase_b) begin
        root_a_next  = end_root;
        rank_a_next  = end_rank;
        phase_b_next = 1'b1;
        start_next   = start_b;
        node_next    = start_b;
        state_next   = ST_UP;
      end else begin
        root_next      = end_root;
        root_rank_next = end_rank;
        state_next     = ST_LINK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_SWEEP;
      sweep_cnt    <= '0;
      clearing     <= 1'b0;
      total        <= '0;
      vertex_count <= 11'd1024;
      m_tvalid     <= 1'b0;
      phase_b      <= 1'b0;
    end else begin
      state     <= state_next;
      sweep_cnt <= sweep_cnt_next;
      clearing  <= clearing_next;
      total     <= total_next;
      m_tvalid  <= m_tvalid_next;
      phase_b   <= phase_b_next;
      if (cfg_we) begin
        vertex_count <= cfg_wdata;
      end
    end
    // payload
    node         <= node_next;
    start        <= start_next;
    start_b      <= start_b_next;
    root         <= root_next;
    root_rank    <= root_rank_next;
    root_a       <= root_a_next;
    rank_a       <= rank_a_next;
    weight_reg   <= weight_reg_next;
    res_accepted <= res_accepted_next;
    res_status   <= res_status_next;
    out_accepted <= out_accepted_next;
    out_total    <= out_total_next;
    out_status   <= out_status_next;
  end

  // total only falls on a clear item
  a_total_monotonic: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && !$past(s_tvalid && s_tready && s_tuser[0])
      |-> total >= $past(total))
    else $error("running total decreased without a clear");

  // outside the sweep no entry is ever pointed at itself
  a_no_self_link: assert property (@(posedge clk) disable iff (rst)
    wr.parent_we && state != ST_SWEEP |-> pw_addr != pw_data)
    else $error("parent write would make a node its own parent");

  a_cleared_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == STATUS_CLEARED |-> out_total == '0 && !out_accepted)
    else $error("clear result carries a total or an accept");

  a_accept_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_accepted |-> m_tuser == STATUS_EDGE)
    else $error("accepted edge with a non-edge status");

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state != ST_IDLE)
    else $error("item accepted but no work started");

endmodule

`default_nettype wire

/* rtl/kuf_table.sv */
// ----------------------------------------------------------------------------
// kuf_table
// parent and rank memories, one write and one registered read port each
// ----------------------------------------------------------------------------
`default_nettype none

module kuf_table
  import kuf_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire kuf_wr_t                  wr,
  input  wire logic [$clog2(DEPTH)-1:0] parent_waddr,
  input  wire logic [$clog2(DEPTH)-1:0] parent_wdata,
  input  wire logic [$clog2(DEPTH)-1:0] rank_waddr,
  input  wire logic [RANK_W-1:0]        rank_wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [$clog2(DEPTH)-1:0] parent_rdata,
  output logic      [RANK_W-1:0]        rank_rdata
);

  logic [$clog2(DEPTH)-1:0] parent_mem [DEPTH];
  logic [RANK_W-1:0]        rank_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.parent_we) begin
      parent_mem[parent_waddr] <= parent_wdata;
    end
    parent_rdata <= parent_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    rank_rdata <= rank_mem[raddr];
  end

endmodule

`default_nettype wire
